FILE: rtl/delta_r_nearest_jet_matcher_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delta-R nearest jet matcher
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DELTA_R_NEAREST_JET_MATCHER_UNIT_MACROS_SVH
`define DELTA_R_NEAREST_JET_MATCHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DJM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed.");
`define DJM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed.");
`else
`define DJM_ASSERT_IMP(label, clk, rst, ante, cons)
`define DJM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/djm_pkg.sv
// ----------------------------------------------------------------------------
// Delta-R nearest jet matcher package
// Sizes, codes and the transaction token shared by the cell row and the top.
// ----------------------------------------------------------------------------
package djm_pkg;

   localparam int MAX_REFS = 32;
   localparam int SLOT_W   = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
   localparam int COUNT_W  = $clog2(MAX_REFS + 1);

   localparam int PT_W      = 16;
   localparam int ETA_W     = 12;
   localparam int PHI_W     = 11;
   localparam int MASS_W    = 16;
   localparam int DR_W      = 23;
   localparam int IDX_W     = 5;
   localparam int DPHI_W    = 10;
   localparam int DETA_SQ_W = 2 * ETA_W;
   localparam int DPHI_SQ_W = 2 * DPHI_W;
   localparam int DR_SUM_W  = DETA_SQ_W + 1;

   localparam logic [PHI_W-1:0] PHI_HALF = PHI_W'(720);
   localparam logic [PHI_W-1:0] PHI_FULL = PHI_W'(1440);

   localparam logic [DR_W-1:0] DR_SQ_LIMIT_RESET = DR_W'(6432);

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_MATCH = 1'b1;

   typedef struct packed {
      logic                     probe;
      logic                     store;
      logic [SLOT_W-1:0]        slot;
      logic [COUNT_W-1:0]       count;
      logic [PT_W-1:0]          pt;
      logic signed [ETA_W-1:0]  eta;
      logic signed [PHI_W-1:0]  phi;
      logic [MASS_W-1:0]        mass;
      logic                     found;
      logic [DR_W-1:0]          best_dr;
      logic [PT_W-1:0]          best_dpt;
      logic [SLOT_W-1:0]        best_idx;
      logic [PT_W-1:0]          best_pt;
      logic [MASS_W-1:0]        best_mass;
   } token_type;

endpackage

FILE: rtl/djm_cell.sv
// ----------------------------------------------------------------------------
// Delta-R matcher reference cell
// Holds one reference jet. Loads store into the cell whose slot they name;
// probes compare against the stored jet over two stages and carry the best
// candidate so far to the next cell.
// ----------------------------------------------------------------------------
module djm_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic [djm_pkg::SLOT_W-1:0]       cell_id,
   input  logic [djm_pkg::DR_W-1:0]         dr_sq_limit,
   input  logic                             tok_valid_in,
   input  djm_pkg::token_type               tok_in,
   output logic                             tok_valid_out,
   output djm_pkg::token_type               tok_out
);

   logic [djm_pkg::PT_W-1:0]           ref_pt_ff;
   logic signed [djm_pkg::ETA_W-1:0]   ref_eta_ff;
   logic signed [djm_pkg::PHI_W-1:0]   ref_phi_ff;
   logic [djm_pkg::MASS_W-1:0]         ref_mass_ff;

   logic                               mid_valid_ff;
   logic                               mid_live_ff;
   logic                               mid_live_in;
   djm_pkg::token_type                 mid_tok_ff;
   logic [djm_pkg::DETA_SQ_W-1:0]      mid_deta_sq_ff;
   logic [djm_pkg::DETA_SQ_W-1:0]      mid_deta_sq_in;
   logic [djm_pkg::DPHI_SQ_W-1:0]      mid_dphi_sq_ff;
   logic [djm_pkg::DPHI_SQ_W-1:0]      mid_dphi_sq_in;

   logic                               out_valid_ff;
   djm_pkg::token_type                 out_tok_ff;
   djm_pkg::token_type                 out_tok_in;

   logic                               store_hit;
   logic [djm_pkg::ETA_W:0]            eta_diff;
   logic [djm_pkg::ETA_W:0]            eta_diff_neg;
   logic [djm_pkg::ETA_W-1:0]          deta;
   logic [djm_pkg::PHI_W:0]            phi_diff;
   logic [djm_pkg::PHI_W:0]            phi_diff_neg;
   logic [djm_pkg::PHI_W-1:0]          dphi_abs;
   logic [djm_pkg::DPHI_W-1:0]         dphi;

   logic [djm_pkg::DR_SUM_W-1:0]       dr_sum;
   logic                               in_limit;
   logic [djm_pkg::PT_W-1:0]           dpt;
   logic                               take;

   // First stage: angular differences and their squares.
   always_comb begin
      store_hit    = tok_valid_in && tok_in.store && (tok_in.slot == cell_id);
      mid_live_in  = tok_valid_in && tok_in.probe &&
                     (djm_pkg::COUNT_W'(cell_id) < tok_in.count);
      eta_diff     = {tok_in.eta[djm_pkg::ETA_W-1], tok_in.eta} -
                     {ref_eta_ff[djm_pkg::ETA_W-1], ref_eta_ff};
      eta_diff_neg = -eta_diff;
      deta         = eta_diff[djm_pkg::ETA_W] ? eta_diff_neg[djm_pkg::ETA_W-1:0]
                                              : eta_diff[djm_pkg::ETA_W-1:0];
      phi_diff     = {tok_in.phi[djm_pkg::PHI_W-1], tok_in.phi} -
                     {ref_phi_ff[djm_pkg::PHI_W-1], ref_phi_ff};
      phi_diff_neg = -phi_diff;
      dphi_abs     = phi_diff[djm_pkg::PHI_W] ? phi_diff_neg[djm_pkg::PHI_W-1:0]
                                              : phi_diff[djm_pkg::PHI_W-1:0];
      if (dphi_abs > djm_pkg::PHI_HALF) begin
         if (dphi_abs > djm_pkg::PHI_FULL) begin
            dphi = djm_pkg::DPHI_W'(dphi_abs - djm_pkg::PHI_FULL);
         end else begin
            dphi = djm_pkg::DPHI_W'(djm_pkg::PHI_FULL - dphi_abs);
         end
      end else begin
         dphi = djm_pkg::DPHI_W'(dphi_abs);
      end
      mid_deta_sq_in = djm_pkg::DETA_SQ_W'(deta) * djm_pkg::DETA_SQ_W'(deta);
      mid_dphi_sq_in = djm_pkg::DPHI_SQ_W'(dphi) * djm_pkg::DPHI_SQ_W'(dphi);
   end

   // Second stage: distance, limit check and best-candidate update.
   always_comb begin
      dr_sum   = djm_pkg::DR_SUM_W'(mid_deta_sq_ff) + djm_pkg::DR_SUM_W'(mid_dphi_sq_ff);
      in_limit = dr_sum < djm_pkg::DR_SUM_W'(dr_sq_limit);
      dpt      = (mid_tok_ff.pt >= ref_pt_ff) ? (mid_tok_ff.pt - ref_pt_ff)
                                              : (ref_pt_ff - mid_tok_ff.pt);
      take     = mid_live_ff && in_limit &&
                 (!mid_tok_ff.found ||
                  (dr_sum < djm_pkg::DR_SUM_W'(mid_tok_ff.best_dr)) ||
                  ((dr_sum == djm_pkg::DR_SUM_W'(mid_tok_ff.best_dr)) &&
                   (dpt < mid_tok_ff.best_dpt)));
      out_tok_in = mid_tok_ff;
      if (take) begin
         out_tok_in.found     = 1'b1;
         out_tok_in.best_dr   = dr_sum[djm_pkg::DR_W-1:0];
         out_tok_in.best_dpt  = dpt;
         out_tok_in.best_idx  = cell_id;
         out_tok_in.best_pt   = ref_pt_ff;
         out_tok_in.best_mass = ref_mass_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         mid_live_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         mid_valid_ff <= tok_valid_in;
         mid_live_ff  <= mid_live_in;
         out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mid_tok_ff     <= tok_in;
         mid_deta_sq_ff <= mid_deta_sq_in;
         mid_dphi_sq_ff <= mid_dphi_sq_in;
         out_tok_ff     <= out_tok_in;
         if (store_hit) begin
            ref_pt_ff   <= tok_in.pt;
            ref_eta_ff  <= tok_in.eta;
            ref_phi_ff  <= tok_in.phi;
            ref_mass_ff <= tok_in.mass;
         end
      end
   end

   assign tok_valid_out = out_valid_ff;
   assign tok_out       = out_tok_ff;

endmodule

FILE: rtl/delta_r_nearest_jet_matcher_unit.sv
// ----------------------------------------------------------------------------
// Delta-R nearest jet matcher
// A match result passes through the middle and output registers of every
// reference cell in turn and then the response register.
// Throughput: one transaction per cycle; the whole cell row holds while a
// result waits on the output and is not taken.
// Reset clears the table count and all transactions in flight and sets the
// distance limit to 6432.
// ----------------------------------------------------------------------------
`include "delta_r_nearest_jet_matcher_unit_macros.svh"

module delta_r_nearest_jet_matcher_unit (
   input  logic                        clock,
   input  logic                        reset,
   // tdata: jet_pt[15:0], jet_eta[27:16], jet_phi[38:28], jet_mass[54:39]
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [55:0]                 req_tdata,
   // tuser: cmd[0], first_of_event[1]
   input  logic [1:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // tdata: matched_pt[15:0], matched_mass[31:16], matched_dr_sq[54:32],
   //        matched_index[59:55]
   output logic [63:0]                 rsp_tdata,
   // tuser: found[0]
   output logic                        rsp_tuser,
   input  logic                        csr_wr_en,
   input  logic [djm_pkg::DR_W-1:0]    csr_wr_data
);

   logic                               enable;
   logic                               req_accept;
   logic                               req_probe;
   logic                               req_first;
   logic [djm_pkg::COUNT_W-1:0]        count_ff;
   logic [djm_pkg::COUNT_W-1:0]        count_in;
   logic [djm_pkg::DR_W-1:0]           limit_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_found_ff;
   logic [djm_pkg::PT_W-1:0]           rsp_pt_ff;
   logic [djm_pkg::MASS_W-1:0]         rsp_mass_ff;
   logic [djm_pkg::DR_W-1:0]           rsp_dr_ff;
   logic [djm_pkg::IDX_W-1:0]          rsp_idx_ff;
   logic                               not_full;

   logic [djm_pkg::MAX_REFS:0]         link_valid;
   djm_pkg::token_type                 link_tok [djm_pkg::MAX_REFS+1];

   assign enable     = !rsp_valid_ff || rsp_tready;
   assign req_tready = enable;
   assign req_accept = req_tvalid && enable;
   assign req_probe  = req_tuser[0] == djm_pkg::CMD_MATCH;
   assign req_first  = req_tuser[1];
   assign not_full   = count_ff < djm_pkg::COUNT_W'(djm_pkg::MAX_REFS);

   always_comb begin
      link_valid[0]      = req_accept;
      link_tok[0]        = '0;
      link_tok[0].probe  = req_probe;
      link_tok[0].store  = !req_probe && (req_first || not_full);
      link_tok[0].slot   = req_first ? '0 : djm_pkg::SLOT_W'(count_ff);
      link_tok[0].count  = count_ff;
      link_tok[0].pt     = req_tdata[15:0];
      link_tok[0].eta    = req_tdata[27:16];
      link_tok[0].phi    = req_tdata[38:28];
      link_tok[0].mass   = req_tdata[54:39];
   end

   always_comb begin
      count_in = count_ff;
      if (req_accept && !req_probe) begin
         if (req_first) begin
            count_in = djm_pkg::COUNT_W'(1);
         end else if (not_full) begin
            count_in = count_ff + djm_pkg::COUNT_W'(1);
         end
      end
   end

   for (genvar k = 0; k < djm_pkg::MAX_REFS; k++) begin : g_cell
      djm_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .enable        (enable),
         .cell_id       (djm_pkg::SLOT_W'(k)),
         .dr_sq_limit   (limit_ff),
         .tok_valid_in  (link_valid[k]),
         .tok_in        (link_tok[k]),
         .tok_valid_out (link_valid[k+1]),
         .tok_out       (link_tok[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         limit_ff     <= djm_pkg::DR_SQ_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (enable) begin
            rsp_valid_ff <= link_valid[djm_pkg::MAX_REFS] &&
                            link_tok[djm_pkg::MAX_REFS].probe;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_found_ff <= link_tok[djm_pkg::MAX_REFS].found;
         rsp_pt_ff    <= link_tok[djm_pkg::MAX_REFS].best_pt;
         rsp_mass_ff  <= link_tok[djm_pkg::MAX_REFS].best_mass;
         rsp_dr_ff    <= link_tok[djm_pkg::MAX_REFS].best_dr;
         rsp_idx_ff   <= djm_pkg::IDX_W'(link_tok[djm_pkg::MAX_REFS].best_idx);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {4'd0, rsp_idx_ff, rsp_dr_ff, rsp_mass_ff, rsp_pt_ff};

   `DJM_ASSERT_IMP(a_count_in_range, clock, reset, 1'b1, count_ff <= djm_pkg::COUNT_W'(djm_pkg::MAX_REFS))
   `DJM_ASSERT_IMP(a_stall_holds_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `DJM_ASSERT_IMP(a_miss_is_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   `DJM_ASSERT_NXT(a_full_load_dropped, clock, reset, req_accept && !req_probe && !req_first && !not_full, count_ff == djm_pkg::COUNT_W'(djm_pkg::MAX_REFS))

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Delta-R nearest jet matcher testbench
// Loads reference jets into the matcher and sends probe jets against them.
// Every probe is predicted from a local copy of the reference table and the
// distance limit, and each result transaction is compared field by field in
// arrival order. Directed cases cover the field extremes, phi wrap, both tie
// rules, a full table and the extreme limits; random events follow, with
// random idle bursts on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_TURN     = 720;
   localparam int FULL_TURN     = 1440;
   localparam int DRAIN_CYCLES  = 2 * djm_pkg::MAX_REFS + 10;
   localparam int HOLD_CYCLES   = 300;
   localparam int WATCHDOG_IDLE = 4000;

   typedef logic signed [djm_pkg::ETA_W-1:0] eta_type;
   typedef logic signed [djm_pkg::PHI_W-1:0] phi_type;

   typedef struct packed {
      logic                       found;
      logic [djm_pkg::PT_W-1:0]   pt;
      logic [djm_pkg::MASS_W-1:0] mass;
      logic [djm_pkg::DR_W-1:0]   dr_sq;
      logic [djm_pkg::IDX_W-1:0]  index;
   } match_result_type;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_tvalid  = 1'b0;
   logic                       req_tready;
   logic [55:0]                req_tdata   = '0;
   logic [1:0]                 req_tuser   = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready  = 1'b0;
   logic [63:0]                rsp_tdata;
   logic                       rsp_tuser;
   logic                       csr_wr_en   = 1'b0;
   logic [djm_pkg::DR_W-1:0]   csr_wr_data = '0;

   logic [djm_pkg::PT_W-1:0]   jet_store_pt   [djm_pkg::MAX_REFS];
   eta_type                    jet_store_eta  [djm_pkg::MAX_REFS];
   phi_type                    jet_store_phi  [djm_pkg::MAX_REFS];
   logic [djm_pkg::MASS_W-1:0] jet_store_mass [djm_pkg::MAX_REFS];
   int                         jet_store_count = 0;
   logic [djm_pkg::DR_W-1:0]   dr_limit        = djm_pkg::DR_SQ_LIMIT_RESET;

   match_result_type  pending_matches[$];
   match_result_type  oldest_match;
   int                failures      = 0;
   int                sent_items    = 0;
   int                quiet_cycles  = 0;
   int                stall_left    = 0;
   int                hold_left     = 0;
   bit                hold_request  = 1'b0;
   bit                idling        = 1'b1;
   bit                quiet         = 1'b0;

   delta_r_nearest_jet_matcher_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic match_result_type nearest_reference(logic [djm_pkg::PT_W-1:0] pt,
                                                          eta_type eta, phi_type phi);
      match_result_type best;
      int deta, dphi, cand_dr, dpt, best_dist, best_dpt;
      best = '0;
      best_dist = 0;
      best_dpt = 0;
      for (int k = 0; k < jet_store_count; k++) begin
         deta = int'(eta) - int'(jet_store_eta[k]);
         if (deta < 0) deta = -deta;
         dphi = int'(phi) - int'(jet_store_phi[k]);
         if (dphi < 0) dphi = -dphi;
         if (dphi > HALF_TURN) dphi = (dphi > FULL_TURN) ? dphi - FULL_TURN : FULL_TURN - dphi;
         cand_dr = deta * deta + dphi * dphi;
         if (cand_dr < int'(dr_limit)) begin
            dpt = int'(pt) - int'(jet_store_pt[k]);
            if (dpt < 0) dpt = -dpt;
            if (!best.found || cand_dr < best_dist ||
                (cand_dr == best_dist && dpt < best_dpt)) begin
               best_dist  = cand_dr;
               best_dpt   = dpt;
               best.found = 1'b1;
               best.pt    = jet_store_pt[k];
               best.mass  = jet_store_mass[k];
               best.dr_sq = djm_pkg::DR_W'(cand_dr);
               best.index = djm_pkg::IDX_W'(k);
            end
         end
      end
      return best;
   endfunction

   function automatic void store_reference(logic first, logic [djm_pkg::PT_W-1:0] pt,
                                           eta_type eta, phi_type phi,
                                           logic [djm_pkg::MASS_W-1:0] mass);
      if (first) jet_store_count = 0;
      if (jet_store_count < djm_pkg::MAX_REFS) begin
         jet_store_pt[jet_store_count]   = pt;
         jet_store_eta[jet_store_count]  = eta;
         jet_store_phi[jet_store_count]  = phi;
         jet_store_mass[jet_store_count] = mass;
         jet_store_count++;
      end
   endfunction

   function automatic eta_type random_eta();
      if ($urandom_range(0, 7) == 0) return eta_type'($urandom);
      return eta_type'($urandom_range(0, 2292) - 1146);
   endfunction

   function automatic phi_type random_phi();
      if ($urandom_range(0, 7) == 0) return phi_type'($urandom);
      return phi_type'($urandom_range(0, 1439) - 720);
   endfunction

   task automatic send_jet(logic cmd, logic first, logic [djm_pkg::PT_W-1:0] pt,
                           eta_type eta, phi_type phi, logic [djm_pkg::MASS_W-1:0] mass);
      if (idling && !quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, mass, phi, eta, pt};
      req_tuser  <= {first, cmd};
      if (cmd == djm_pkg::CMD_MATCH) pending_matches.push_back(nearest_reference(pt, eta, phi));
      else store_reference(first, pt, eta, phi, mass);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [djm_pkg::DR_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      dr_limit = value;
   endtask

   task automatic probe_near_reference();
      int k, spread, e, p;
      logic [djm_pkg::PT_W-1:0] pt;
      k = $urandom_range(0, jet_store_count - 1);
      case ($urandom_range(0, 3))
         0: spread = 1;
         1: spread = 12;
         2: spread = 80;
         default: spread = 400;
      endcase
      e = int'(jet_store_eta[k]) + int'($urandom_range(0, 2 * spread)) - spread;
      p = int'(jet_store_phi[k]) + int'($urandom_range(0, 2 * spread)) - spread;
      if (p > HALF_TURN - 1) p -= FULL_TURN;
      else if (p < -HALF_TURN) p += FULL_TURN;
      if ($urandom_range(0, 1))
         pt = jet_store_pt[k] + djm_pkg::PT_W'($urandom_range(0, 8)) - djm_pkg::PT_W'(4);
      else pt = djm_pkg::PT_W'($urandom);
      send_jet(djm_pkg::CMD_MATCH, 1'($urandom_range(0, 1)), pt, eta_type'(e), phi_type'(p),
               djm_pkg::MASS_W'($urandom));
   endtask

   task automatic test_directed_cases();
      send_jet(djm_pkg::CMD_MATCH, 1'b1, 16'd1234, 12'sd0, 11'sd0, 16'hFFFF);
      send_jet(djm_pkg::CMD_LOAD, 1'b1, 16'hFFFF, 12'sd1146, 11'sd719, 16'hFFFF);
      send_jet(djm_pkg::CMD_LOAD, 1'b0, 16'h0000, -12'sd1146, -11'sd720, 16'h0000);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'h0000, 12'sd1146, -11'sd720, 16'h0000);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'h0000, -12'sd1146, 11'sd719, 16'h0000);
      send_jet(djm_pkg::CMD_LOAD, 1'b0, 16'd100, 12'sd1146, 11'sd719, 16'd5);
      send_jet(djm_pkg::CMD_LOAD, 1'b0, 16'd100, 12'sd1146, 11'sd719, 16'd6);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd100, 12'sd1146, 11'sd719, 16'd0);
      send_jet(djm_pkg::CMD_LOAD, 1'b0, 16'd0, 12'sd0, 11'sd0, 16'd1);
      send_jet(djm_pkg::CMD_LOAD, 1'b0, 16'd200, 12'sd0, 11'sd0, 16'd2);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd100, 12'sd0, 11'sd0, 16'd0);
      send_jet(djm_pkg::CMD_LOAD, 1'b0, 16'd1, -12'sd2048, -11'sd1024, 16'd3);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd1, 12'sd2047, 11'sd1023, 16'd0);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd1, -12'sd2048, 11'sd1023, 16'd0);
      send_jet(djm_pkg::CMD_LOAD, 1'b1, 16'd7, 12'sd10, 11'sd10, 16'd9);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd7, 12'sd1146, 11'sd719, 16'd0);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd7, 12'sd10, 11'sd70, 16'd0);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd7, 12'sd10, 11'sd91, 16'd0);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd7, 12'sd10, 11'sd90, 16'd0);
   endtask

   task automatic test_limit_extremes();
      write_limit('0);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd7, 12'sd10, 11'sd10, 16'd0);
      write_limit(djm_pkg::DR_W'(1));
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd7, 12'sd10, 11'sd10, 16'd0);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd7, 12'sd10, 11'sd11, 16'd0);
      write_limit('1);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd7, -12'sd2037, 11'sd10, 16'd0);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd7, 12'sd2047, -11'sd1024, 16'd0);
      write_limit(djm_pkg::DR_SQ_LIMIT_RESET);
   endtask

   task automatic test_table_full();
      for (int k = 0; k < djm_pkg::MAX_REFS; k++)
         send_jet(djm_pkg::CMD_LOAD, k == 0, djm_pkg::PT_W'(k), eta_type'(k * 20), 11'sd0,
                  djm_pkg::MASS_W'(k + 300));
      send_jet(djm_pkg::CMD_LOAD, 1'b0, 16'd7777, 12'sd1000, 11'sd0, 16'd7777);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd7777, 12'sd1000, 11'sd0, 16'd0);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd0, 12'sd0, 11'sd0, 16'd0);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd31, 12'sd620, 11'sd0, 16'd0);
      send_jet(djm_pkg::CMD_LOAD, 1'b1, 16'd42, 12'sd1000, 11'sd0, 16'd43);
      send_jet(djm_pkg::CMD_MATCH, 1'b0, 16'd42, 12'sd1000, 11'sd0, 16'd0);
   endtask

   task automatic test_random_events(int target);
      int loads, probes, k;
      logic first;
      logic [djm_pkg::PT_W-1:0] pt;
      eta_type eta;
      phi_type phi;
      while (sent_items < target) begin
         idling = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) loads = 0;
         else if ($urandom_range(0, 6) == 0) loads = $urandom_range(28, 40);
         else loads = $urandom_range(1, 12);
         for (int i = 0; i < loads; i++) begin
            first = (i == 0) ? 1'b1 : ($urandom_range(0, 29) == 0);
            pt = djm_pkg::PT_W'($urandom);
            if (i > 0 && jet_store_count > 0 && $urandom_range(0, 3) == 0) begin
               k = $urandom_range(0, jet_store_count - 1);
               eta = jet_store_eta[k];
               phi = jet_store_phi[k];
               if ($urandom_range(0, 1)) pt = jet_store_pt[k];
            end else begin
               eta = random_eta();
               phi = random_phi();
            end
            send_jet(djm_pkg::CMD_LOAD, first, pt, eta, phi, djm_pkg::MASS_W'($urandom));
         end
         probes = $urandom_range(1, 8);
         for (int i = 0; i < probes; i++) begin
            if (jet_store_count > 0 && $urandom_range(0, 3) != 0) probe_near_reference();
            else send_jet(djm_pkg::CMD_MATCH, 1'($urandom_range(0, 1)),
                          djm_pkg::PT_W'($urandom), random_eta(), random_phi(),
                          djm_pkg::MASS_W'($urandom));
         end
      end
   endtask

   task automatic test_stalled_output();
      idling = 1'b0;
      for (int i = 0; i < 8; i++)
         send_jet(djm_pkg::CMD_LOAD, i == 0, djm_pkg::PT_W'($urandom), random_eta(),
                  random_phi(), djm_pkg::MASS_W'($urandom));
      hold_request = 1'b1;
      repeat (200) probe_near_reference();
   endtask

   task automatic compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_matches.size() == 0) begin
            $display("%0t: result transaction with none pending, expected none, actual %h %b",
                     $time, rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            oldest_match = pending_matches.pop_front();
            compare_field("found", oldest_match.found, rsp_tuser);
            compare_field("matched_pt", oldest_match.pt, rsp_tdata[15:0]);
            compare_field("matched_mass", oldest_match.mass, rsp_tdata[31:16]);
            compare_field("matched_dr_sq", oldest_match.dr_sq, rsp_tdata[54:32]);
            compare_field("matched_index", oldest_match.index, rsp_tdata[59:55]);
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idling && !quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 4) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_IDLE) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_limit_extremes();
      test_table_full();
      test_random_events(700);
      write_limit('1);
      test_random_events(1000);
      write_limit(djm_pkg::DR_W'(1));
      test_random_events(1150);
      write_limit('0);
      test_random_events(1250);
      write_limit(djm_pkg::DR_W'($urandom_range(100, 300000)));
      test_stalled_output();
      test_random_events(1600);
      write_limit(djm_pkg::DR_SQ_LIMIT_RESET);
      quiet = 1'b1;
      test_random_events(1850);
      wait_drained();
      if (failures == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
